FILE: hw/rtl/eigs_pkg.sv
// Shared types and constants for the exposure index gain sequencer.
// Holds the action and register codes, reset values and the analog gain ladder.
// No dependencies.
package eigs_pkg;

    // action codes carried in tuser
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_STEP = 2'd1;
    localparam logic [1:0] ACT_SET  = 2'd2;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_MAX_INDEX = 2'd0;
    localparam logic [1:0] REG_RATE_LOW  = 2'd1;
    localparam logic [1:0] REG_RATE_HIGH = 2'd2;

    localparam logic [7:0]  MAX_INDEX_RESET = 8'hFF;
    localparam logic [15:0] RATE_LOW_RESET  = 16'h0354;
    localparam logic [15:0] RATE_HIGH_RESET = 16'h0410;

    // frame rate codes
    localparam logic [1:0] RATE_30 = 2'd0;
    localparam logic [1:0] RATE_25 = 2'd1;
    localparam logic [1:0] RATE_20 = 2'd2;

    localparam logic [12:0] GAIN_UNITY   = 13'd256;
    localparam logic [12:0] GAIN_SIXTEEN = 13'd4096;
    localparam logic [7:0]  CODE_SIXTEEN = 8'hF0;
    localparam logic [7:0]  CODE_UNITY   = 8'h00;
    localparam logic [6:0]  LADDER_LAST  = 7'd64;

    // status of the gain search unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_gs_stat;

    // gain ladder, 65 steps, Q5.8
    function automatic logic [12:0] ladder(input logic [6:0] i);
        logic [12:0] v;
        unique case (i)
            7'd0:  v = 13'd256;   7'd1:  v = 13'd271;   7'd2:  v = 13'd289;
            7'd3:  v = 13'd305;   7'd4:  v = 13'd320;   7'd5:  v = 13'd335;
            7'd6:  v = 13'd353;   7'd7:  v = 13'd369;   7'd8:  v = 13'd384;
            7'd9:  v = 13'd399;   7'd10: v = 13'd417;   7'd11: v = 13'd433;
            7'd12: v = 13'd448;   7'd13: v = 13'd463;   7'd14: v = 13'd481;
            7'd15: v = 13'd497;   7'd16: v = 13'd512;   7'd17: v = 13'd545;
            7'd18: v = 13'd576;   7'd19: v = 13'd609;   7'd20: v = 13'd640;
            7'd21: v = 13'd673;   7'd22: v = 13'd704;   7'd23: v = 13'd737;
            7'd24: v = 13'd768;   7'd25: v = 13'd801;   7'd26: v = 13'd832;
            7'd27: v = 13'd865;   7'd28: v = 13'd896;   7'd29: v = 13'd929;
            7'd30: v = 13'd960;   7'd31: v = 13'd993;   7'd32: v = 13'd1024;
            7'd33: v = 13'd1088;  7'd34: v = 13'd1152;  7'd35: v = 13'd1216;
            7'd36: v = 13'd1280;  7'd37: v = 13'd1344;  7'd38: v = 13'd1408;
            7'd39: v = 13'd1472;  7'd40: v = 13'd1536;  7'd41: v = 13'd1600;
            7'd42: v = 13'd1664;  7'd43: v = 13'd1728;  7'd44: v = 13'd1792;
            7'd45: v = 13'd1856;  7'd46: v = 13'd1920;  7'd47: v = 13'd1984;
            7'd48: v = 13'd2048;  7'd49: v = 13'd2176;  7'd50: v = 13'd2304;
            7'd51: v = 13'd2432;  7'd52: v = 13'd2560;  7'd53: v = 13'd2688;
            7'd54: v = 13'd2816;  7'd55: v = 13'd2944;  7'd56: v = 13'd3072;
            7'd57: v = 13'd3200;  7'd58: v = 13'd3328;  7'd59: v = 13'd3456;
            7'd60: v = 13'd3584;  7'd61: v = 13'd3712;  7'd62: v = 13'd3840;
            7'd63: v = 13'd3968;  7'd64: v = 13'd4096;
            default: v = 13'd4096;
        endcase
        return v;
    endfunction

    // coarse gain code of a 16-step band
    function automatic logic [3:0] coarse_of_band(input logic [1:0] band);
        logic [3:0] c;
        unique case (band)
            2'd0: c = 4'd0;
            2'd1: c = 4'd1;
            2'd2: c = 4'd3;
            2'd3: c = 4'd7;
            default: c = 4'd0;
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/eigs_gain_search.sv
// Iterative analog gain to coarse/fine code search over the gain ladder.
// One ladder compare per cycle; uses eigs_pkg for the ladder and status type.
module eigs_gain_search
    import eigs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [12:0] i_gain,
    output t_gs_stat    o_stat,
    output logic [7:0]  o_code
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [6:0]  r_i, n_i;
    logic [12:0] r_g, n_g;
    logic [7:0]  r_code, n_code;
    logic [5:0]  step;

    assign step = 6'(r_i - 7'd1);

    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_i    = r_i;
        n_g    = r_g;
        n_code = r_code;
        if (i_start) begin
            n_g    = i_gain;
            n_done = 1'b0;
            n_busy = 1'b0;
            n_i    = 7'd1;
            priority if (i_gain >= GAIN_SIXTEEN) begin
                n_code = CODE_SIXTEEN;
                n_done = 1'b1;
            end else if (i_gain < GAIN_UNITY) begin
                n_code = CODE_UNITY;
                n_done = 1'b1;
            end else begin
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            // stop at the first ladder step above the gain
            if (r_g < ladder(r_i) || r_i == LADDER_LAST) begin
                n_code = {coarse_of_band(step[5:4]), step[3:0]};
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_i = r_i + 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_i    <= n_i;
        r_g    <= n_g;
        r_code <= n_code;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_code      = r_code;

endmodule

FILE: hw/rtl/exposure_index_gain_sequencer.sv
// Top level of the exposure index gain sequencer: APB registers, exposure
// table memory, step sequencer and output register. Uses eigs_pkg and eigs_gain_search.

// A load (tuser 0) writes one exposure table entry, a set (tuser 2) stores a new
// exposure index, and a step (tuser 1) adds ev_delta to the index, clamps it to
// 0..max_exposure_index, reads the table entry and returns one result item;
// loads, sets and tuser 3 return nothing. The block takes one item at a time.
// A set only updates the index and stays idle. A load or step first reduces
// its index modulo TABLE_DEPTH by repeated subtraction (none when TABLE_DEPTH
// is 256 or more), then a load writes the entry. A step adds a registered
// memory read and then the gain search, which walks the 65-step gain ladder
// one compare per cycle: 1 to 64 compares for gains in 1.0..16.0, then the
// code is flagged; gains outside that range are coded without a walk. A
// finished result sits in the output register while the next item is
// accepted; a second result waits for it to drain. Table entries read before
// they are loaded return undefined data.
module exposure_index_gain_sequencer
    import eigs_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] entry_index, [23:8] entry_time, [36:24] entry_analog_gain,
    // [52:37] entry_digital_gain, [60:53] ev_delta, [63:61] zero
    input  logic [63:0] s_axis_tdata,
    // [1:0] action
    input  logic [1:0]  s_axis_tuser,
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] time_low_byte, [15:8] time_high_byte, [23:16] analog_gain_code,
    // [36:24] digital_gain_out, [38:37] frame_rate_code, [39] rate_changed,
    // [47:40] exposure_index
    output logic [47:0] m_axis_tdata
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MOD  = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_GAIN = 2'd3;

    logic [1:0]  r_state, n_state;

    // configuration registers
    logic [7:0]  r_max_index;
    logic [15:0] r_rate_low;
    logic [15:0] r_rate_high;
    logic        cfg_wr;

    // item state
    logic [7:0]  r_cur, n_cur;
    logic [1:0]  r_last_rate, n_last_rate;
    logic [7:0]  r_mod, n_mod;
    logic        r_is_load, n_is_load;
    logic [44:0] r_entry, n_entry;

    // table memory: {time, analog gain, digital gain}
    logic [44:0] mem [TABLE_DEPTH];
    logic [44:0] r_rd;
    logic [AW-1:0] addr;
    logic        mem_we;
    logic        mem_re;
    logic        mod_more;

    // clamp
    logic signed [9:0] sum;

    // rate selection on the read entry
    logic [15:0] rd_time;
    logic [12:0] rd_again;
    logic [15:0] rd_dgain;
    logic [1:0]  rate;
    logic [1:0]  r_rate, n_rate;

    // gain search
    logic        gs_start;
    t_gs_stat    gs_stat;
    logic [7:0]  gs_code;

    // output register
    logic        r_ovalid, n_ovalid;
    logic [47:0] r_odata, n_odata;
    logic        out_free;
    logic        in_acc;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_index <= MAX_INDEX_RESET;
            r_rate_low  <= RATE_LOW_RESET;
            r_rate_high <= RATE_HIGH_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_MAX_INDEX: r_max_index <= pwdata[7:0];
                REG_RATE_LOW:  r_rate_low  <= pwdata[15:0];
                REG_RATE_HIGH: r_rate_high <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MAX_INDEX: prdata = {24'd0, r_max_index};
            REG_RATE_LOW:  prdata = {16'd0, r_rate_low};
            REG_RATE_HIGH: prdata = {16'd0, r_rate_high};
            default:       prdata = 32'd0;
        endcase
    end

    // ---------------- input side ----------------
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // signed sum of the current index and the delta, clamped in the sequencer
    assign sum = $signed({2'b00, r_cur})
               + $signed({{2{s_axis_tdata[60]}}, s_axis_tdata[60:53]});

    // table address after modulo reduction
    assign mod_more = (32'(r_mod) >= TABLE_DEPTH);
    assign addr     = AW'(r_mod);
    assign mem_we   = (r_state == S_MOD) && !mod_more && r_is_load;
    assign mem_re   = (r_state == S_MOD) && !mod_more && !r_is_load;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[addr] <= r_entry;
        end
        if (mem_re) begin
            r_rd <= mem[addr];
        end
    end

    assign rd_time  = r_rd[44:29];
    assign rd_again = r_rd[28:16];
    assign rd_dgain = r_rd[15:0];

    always_comb begin
        priority if (rd_time > r_rate_high) begin
            rate = RATE_20;
        end else if (rd_time > r_rate_low) begin
            rate = RATE_25;
        end else begin
            rate = RATE_30;
        end
    end

    assign gs_start = (r_state == S_READ);

    eigs_gain_search u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (gs_start),
        .i_gain  (rd_again),
        .o_stat  (gs_stat),
        .o_code  (gs_code)
    );

    assign out_free = !r_ovalid || m_axis_tready;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_last_rate = r_last_rate;
        n_mod       = r_mod;
        n_is_load   = r_is_load;
        n_entry     = r_entry;
        n_rate      = r_rate;
        n_ovalid    = r_ovalid;
        n_odata     = r_odata;

        // drain the output register
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (s_axis_tuser)
                        ACT_LOAD: begin
                            n_mod     = s_axis_tdata[7:0];
                            n_is_load = 1'b1;
                            n_entry   = {s_axis_tdata[23:8],
                                         s_axis_tdata[36:24],
                                         s_axis_tdata[52:37]};
                            n_state   = S_MOD;
                        end
                        ACT_STEP: begin
                            priority if (sum >= $signed({2'b00, r_max_index})) begin
                                n_cur = r_max_index;
                            end else if (sum[9]) begin
                                n_cur = 8'd0;
                            end else begin
                                n_cur = sum[7:0];
                            end
                            n_mod     = n_cur;
                            n_is_load = 1'b0;
                            n_state   = S_MOD;
                        end
                        ACT_SET: begin
                            n_cur = s_axis_tdata[7:0];
                        end
                        default: ;  // unused action: drop
                    endcase
                end
            end
            S_MOD: begin
                if (mod_more) begin
                    n_mod = r_mod - 8'(TABLE_DEPTH);
                end else if (r_is_load) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                // entry is in r_rd; pick the rate and start the gain search
                n_rate  = rate;
                n_state = S_GAIN;
            end
            S_GAIN: begin
                if (gs_stat.done && !gs_stat.busy && out_free) begin
                    n_ovalid    = 1'b1;
                    n_odata     = {r_cur,
                                   (r_rate != r_last_rate),
                                   r_rate,
                                   rd_dgain[15:3],
                                   gs_code,
                                   rd_time[15:8],
                                   rd_time[7:0]};
                    n_last_rate = r_rate;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= 8'd0;
            r_last_rate <= RATE_30;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_last_rate <= n_last_rate;
            r_ovalid    <= n_ovalid;
        end
        r_mod     <= n_mod;
        r_is_load <= n_is_load;
        r_entry   <= n_entry;
        r_rate    <= n_rate;
        r_odata   <= n_odata;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule
